// File: hw/rtl/bcs_pkg.sv
`default_nettype none
package bcs_pkg;

    localparam int MAX_ITEMS = 1024;
    localparam int POS_W = $clog2(MAX_ITEMS);
    localparam logic [16:0] Q16_ONE = 17'h10000;

    localparam logic [2:0] MODE_FIRST = 3'd0;
    localparam logic [2:0] MODE_COST  = 3'd1;
    localparam logic [2:0] MODE_MAJOR = 3'd2;
    localparam logic [2:0] MODE_STEEP = 3'd5;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_MINCOV = 2'd1;
    localparam logic [1:0] REG_FAMILY = 2'd2;

    localparam logic [2:0] ST_SELECTED = 3'd0;
    localparam logic [2:0] ST_DEFERRED = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_LOWCOV   = 3'd3;
    localparam logic [2:0] ST_NONE     = 3'd4;

    typedef struct packed {
        logic        item_present;
        logic        last_item;
        logic [31:0] cand_id;
        logic        allowed;
        logic        score_valid;
        logic        segment_valid;
        logic [31:0] total_cost;
        logic [31:0] duration;
        logic [31:0] distance;
        logic [31:0] analyzed_distance;
        logic [31:0] unknown_distance;
        logic [31:0] share_distance;
    } t_in;

    typedef struct packed {
        logic [31:0] evidence_route_id;
        logic        eligible;
        logic [16:0] cov_q16;
        logic [31:0] metric;
        logic        decision_valid;
        logic [2:0]  status;
        logic [9:0]  sel_index;
        logic [31:0] sel_id;
    } t_out;

    // Classified request passed from front to back
    typedef struct packed {
        logic        active;    // present and family enabled
        logic        scored;    // allowed and score valid
        logic        need_div;  // share metric with data
        logic        last_item;
        logic        family;
        logic [31:0] cand_id;
        logic [31:0] total_cost;
        logic [31:0] duration;
        logic [31:0] distance;
        logic [31:0] analyzed;
        logic [31:0] known;
        logic [31:0] share;
    } t_job;

endpackage
`default_nettype wire

// File: hw/rtl/bcs_front.sv
`default_nettype none
module bcs_front
    import bcs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_in        i_data,
    input  wire logic [2:0] i_mode,
    input  wire logic       i_family,
    output logic            o_job_valid,
    input  wire logic       i_job_ready,
    output t_job            o_job
);
    // Two-entry queue toward the back
    t_job       r_q [2];
    logic       r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    t_job       w_job;
    logic       w_push, w_pop;
    logic [31:0] w_unk;

    // Classify the request
    always_comb begin
        w_unk = (i_data.unknown_distance > i_data.analyzed_distance) ?
                i_data.analyzed_distance : i_data.unknown_distance;
        w_job.active     = i_data.item_present & i_family;
        w_job.scored     = i_data.allowed & i_data.score_valid;
        w_job.need_div   = (i_mode >= MODE_MAJOR) && (i_mode <= MODE_STEEP) &&
                           i_data.segment_valid && (i_data.analyzed_distance != 32'd0);
        w_job.last_item  = i_data.last_item;
        w_job.family     = i_family;
        w_job.cand_id    = i_data.cand_id;
        w_job.total_cost = i_data.total_cost;
        w_job.duration   = i_data.duration;
        w_job.distance   = i_data.distance;
        w_job.analyzed   = i_data.analyzed_distance;
        w_job.known      = i_data.analyzed_distance - w_unk;
        w_job.share      = i_data.share_distance;
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid & o_ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign w_pop       = o_job_valid & i_job_ready;
    assign o_job       = r_q[r_rp];

    always_comb begin
        n_wp  = w_push ? ~r_wp : r_wp;
        n_rp  = w_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (w_push) begin
            r_q[r_wp] <= w_job;
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/bcs_div.sv
`default_nettype none
module bcs_div
    import bcs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_num,   // quotient of (num << 16) / den
    input  wire logic [31:0] i_den,
    output logic             o_done,
    output logic [47:0]      o_quot
);
    // Restoring divider, one quotient bit per cycle
    logic [47:0] r_q, n_q;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den, n_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [32:0] w_sh;

    always_comb begin
        n_q = r_q; n_rem = r_rem; n_den = r_den; n_cnt = r_cnt;
        n_busy = r_busy; n_done = 1'b0;
        w_sh = {r_rem[31:0], r_q[47]};
        if (i_start) begin
            n_q = {i_num, 16'd0}; n_rem = 33'd0; n_den = i_den;
            n_cnt = 6'd0; n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = w_sh - {1'b0, r_den};
                n_q = {r_q[46:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_q = {r_q[46:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd47) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_q <= n_q; r_rem <= n_rem; r_den <= n_den; r_cnt <= n_cnt;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule
`default_nettype wire

// File: hw/rtl/bcs_back.sv
`default_nettype none
module bcs_back
    import bcs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_job_valid,
    output logic             o_job_ready,
    input  wire t_job        i_job,
    input  wire logic [2:0]  i_mode,
    input  wire logic [16:0] i_min_cov,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_out             o_data
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV1 = 3'd1;
    localparam logic [2:0] S_DIV2 = 3'd2;
    localparam logic [2:0] S_DONE = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]  r_st, n_st;
    t_job        r_job;
    logic [16:0] r_cov;
    logic [31:0] r_val;
    logic        r_avail;
    logic        r_bvalid, r_any, r_nonempty;
    logic [POS_W-1:0] r_pos, r_bpos;
    logic [31:0] r_bmet, r_bcost, r_bdur, r_bdist, r_bid;
    logic        r_ovalid;
    t_out        r_out;

    logic        w_start;
    logic [31:0] w_num, w_den;
    logic        w_done;
    logic [47:0] w_quot;
    logic        w_elig, w_take, w_tie;
    t_out        w_out;

    bcs_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_start),
        .i_num  (w_num),
        .i_den  (w_den),
        .o_done (w_done),
        .o_quot (w_quot)
    );

    assign o_job_ready = (r_st == S_IDLE);
    assign w_start = ((r_st == S_IDLE) && i_job_valid && i_job.active && i_job.scored &&
                      i_job.need_div) ||
                     ((r_st == S_DIV1) && w_done && (r_job.known != 32'd0));
    assign w_num = (r_st == S_IDLE) ? i_job.known : r_job.share;
    assign w_den = (r_st == S_IDLE) ? i_job.analyzed : r_job.known;

    // Eligibility and comparison against the held best
    always_comb begin
        w_elig = r_job.active && r_job.scored && r_avail && (r_cov >= i_min_cov);
        if (r_job.total_cost != r_bcost)     w_tie = r_job.total_cost < r_bcost;
        else if (r_job.duration != r_bdur)   w_tie = r_job.duration < r_bdur;
        else if (r_job.distance != r_bdist)  w_tie = r_job.distance < r_bdist;
        else                                 w_tie = r_job.cand_id < r_bid;
        if (!r_bvalid)                 w_take = 1'b1;
        else if (i_mode == MODE_FIRST) w_take = 1'b0;
        else if (r_val != r_bmet)
            w_take = (i_mode == MODE_MAJOR) ? (r_val > r_bmet) : (r_val < r_bmet);
        else                           w_take = w_tie;
        w_take = w_take & w_elig;

        w_out = '0;
        if (r_job.active) begin
            w_out.evidence_route_id = r_job.cand_id;
            w_out.eligible = w_elig;
            if (r_job.scored) begin
                w_out.cov_q16 = r_cov;
                w_out.metric = r_val;
            end
        end
        if (r_job.last_item) begin
            w_out.decision_valid = 1'b1;
            if (!r_job.family) w_out.status = ST_DEFERRED;
            else if (!(r_nonempty || r_job.active)) w_out.status = ST_EMPTY;
            else if (r_bvalid || w_take) begin
                w_out.status = ST_SELECTED;
                w_out.sel_index = w_take ? 10'(r_pos) : 10'(r_bpos);
                w_out.sel_id = w_take ? r_job.cand_id : r_bid;
            end else if (r_any || (r_job.active && r_job.scored)) w_out.status = ST_LOWCOV;
            else w_out.status = ST_NONE;
        end
    end

    // Sequence one request: divide if needed, decide, present result
    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (i_job_valid) n_st = (w_start ? S_DIV1 : S_DONE);
            S_DIV1: if (w_done) n_st = w_start ? S_DIV2 : S_DONE;
            S_DIV2: if (w_done) n_st = S_DONE;
            S_DONE: n_st = S_OUT;
            S_OUT:  if (!r_ovalid || i_ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ovalid <= 1'b0;
            r_bvalid <= 1'b0; r_any <= 1'b0; r_nonempty <= 1'b0;
            r_pos <= '0; r_bpos <= '0;
            r_bmet <= '0; r_bcost <= '0; r_bdur <= '0; r_bdist <= '0; r_bid <= '0;
        end else begin
            r_st <= n_st;
            if (r_ovalid && i_ready && (r_st != S_OUT)) r_ovalid <= 1'b0;
            case (r_st)
                S_IDLE: if (i_job_valid) begin
                    r_job <= i_job;
                    if (i_mode == MODE_FIRST || i_mode == MODE_COST) begin
                        r_avail <= 1'b1;
                        r_cov <= Q16_ONE;
                        r_val <= (i_mode == MODE_COST) ? i_job.total_cost : 32'd0;
                    end else begin
                        r_avail <= 1'b0; r_cov <= '0; r_val <= '0;
                    end
                end
                S_DIV1: if (w_done) begin
                    r_cov <= w_quot[16:0];
                    r_avail <= (r_job.known != 32'd0);
                end
                S_DIV2: if (w_done) begin
                    r_val <= (w_quot > 48'(Q16_ONE)) ? 32'(Q16_ONE) : w_quot[31:0];
                end
                S_OUT: if (!r_ovalid || i_ready) begin
                    r_ovalid <= 1'b1;
                    r_out <= w_out;
                    if (r_job.last_item) begin
                        r_bvalid <= 1'b0; r_any <= 1'b0; r_nonempty <= 1'b0;
                        r_pos <= '0; r_bpos <= '0;
                        r_bmet <= '0; r_bcost <= '0; r_bdur <= '0;
                        r_bdist <= '0; r_bid <= '0;
                    end else if (r_job.active) begin
                        r_nonempty <= 1'b1;
                        if (r_job.scored) r_any <= 1'b1;
                        if (w_take) begin
                            r_bvalid <= 1'b1; r_bpos <= r_pos; r_bmet <= r_val;
                            r_bcost <= r_job.total_cost; r_bdur <= r_job.duration;
                            r_bdist <= r_job.distance; r_bid <= r_job.cand_id;
                        end
                        if (r_pos != POS_W'(MAX_ITEMS - 1)) r_pos <= r_pos + POS_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;
endmodule
`default_nettype wire

// File: hw/rtl/best_candidate_selector.sv
`default_nettype none
// Streaming best-candidate selector. Each request carries one candidate
// record; each gives one result with its evidence (coverage, metric,
// eligibility), and the request marked last also gives the decision. A front
// stage classifies requests into a two-entry queue; a back stage runs them one
// at a time through a shared 48-step restoring divider. An active, scored
// share-metric request (modes 2 to 5) with segment data and nonzero analyzed
// distance divides known by analyzed, then share by known if known is nonzero;
// other requests skip the divider. A held result stalls the back stage, and
// a full queue stalls the input. Registers are written through a plain write
// port; the user must write them only while idle (the block does not check).
module best_candidate_selector
    import bcs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_in         i_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_out             o_data,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [16:0] i_cfg_data
);
    logic [2:0]  r_mode;
    logic [16:0] r_min_cov;
    logic        r_family;
    logic        w_jv, w_jr;
    t_job        w_job;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_FIRST;
            r_min_cov <= '0;
            r_family <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE:   r_mode <= i_cfg_data[2:0];
                REG_MINCOV: r_min_cov <= i_cfg_data;
                REG_FAMILY: r_family <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    bcs_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .i_mode(r_mode), .i_family(r_family),
        .o_job_valid(w_jv), .i_job_ready(w_jr), .o_job(w_job)
    );

    bcs_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(w_jv), .o_job_ready(w_jr), .i_job(w_job),
        .i_mode(r_mode), .i_min_cov(r_min_cov),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );
endmodule
`default_nettype wire

// File: tb/tb.sv
`default_nettype none
module tb;
    import bcs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_in         i_data;
    logic        o_valid;
    logic        i_ready;
    t_out        o_data;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [16:0] i_cfg_data;

    best_candidate_selector u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Selector shadow: configuration and running best
    logic [2:0]  sh_mode;
    logic [16:0] sh_min_cov;
    logic        sh_family;
    logic        bst_valid;
    logic [9:0]  bst_pos;
    logic [31:0] bst_metric, bst_cost, bst_dur, bst_dist, bst_id;
    logic        seen_scored, seen_present;
    logic [9:0]  next_pos;

    t_out        expected_results[$];
    int          fail_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_off;
    int          idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void clear_best();
        bst_valid = 1'b0;
        bst_pos = '0;
        bst_metric = '0;
        bst_cost = '0;
        bst_dur = '0;
        bst_dist = '0;
        bst_id = '0;
        seen_scored = 1'b0;
        seen_present = 1'b0;
        next_pos = '0;
    endfunction

    // Compute coverage and metric for one candidate; return availability
    function automatic bit score_candidate(input t_in c, output logic [16:0] cov,
                                           output logic [31:0] val);
        logic [63:0] an, unk, kn, q;
        cov = '0;
        val = '0;
        an = {32'd0, c.analyzed_distance};
        unk = {32'd0, c.unknown_distance};
        if (sh_mode == MODE_FIRST) begin
            cov = Q16_ONE;
            return 1'b1;
        end
        if (sh_mode == MODE_COST) begin
            cov = Q16_ONE;
            val = c.total_cost;
            return 1'b1;
        end
        if (sh_mode > MODE_STEEP) return 1'b0;
        if (!c.segment_valid || an == 0) return 1'b0;
        if (unk > an) unk = an;
        kn = an - unk;
        cov = 17'((kn << 16) / an);
        if (kn == 0) return 1'b0;
        q = ({32'd0, c.share_distance} << 16) / kn;
        if (q > 64'h10000) q = 64'h10000;
        val = q[31:0];
        return 1'b1;
    endfunction

    function automatic bit beats_best(input t_in c, input logic [31:0] val);
        if (!bst_valid) return 1'b1;
        if (sh_mode == MODE_FIRST) return 1'b0;
        if (val != bst_metric)
            return (sh_mode == MODE_MAJOR) ? (val > bst_metric) : (val < bst_metric);
        if (c.total_cost != bst_cost) return c.total_cost < bst_cost;
        if (c.duration != bst_dur) return c.duration < bst_dur;
        if (c.distance != bst_dist) return c.distance < bst_dist;
        return c.cand_id < bst_id;
    endfunction

    // Advance the shadow by one candidate and return its result
    function automatic t_out select_step(input t_in c);
        t_out r;
        logic [16:0] cov;
        logic [31:0] val;
        bit avail;
        r = '0;
        if (c.item_present && sh_family) begin
            r.evidence_route_id = c.cand_id;
            seen_present = 1'b1;
            if (c.allowed && c.score_valid) begin
                seen_scored = 1'b1;
                avail = score_candidate(c, cov, val);
                r.cov_q16 = cov;
                r.metric = val;
                r.eligible = avail && (cov >= sh_min_cov);
            end
            if (r.eligible && beats_best(c, val)) begin
                bst_valid = 1'b1;
                bst_pos = next_pos;
                bst_metric = val;
                bst_cost = c.total_cost;
                bst_dur = c.duration;
                bst_dist = c.distance;
                bst_id = c.cand_id;
            end
            if (next_pos != 10'(MAX_ITEMS - 1)) next_pos++;
        end
        if (c.last_item) begin
            r.decision_valid = 1'b1;
            if (!sh_family) r.status = ST_DEFERRED;
            else if (!seen_present) r.status = ST_EMPTY;
            else if (bst_valid) begin
                r.status = ST_SELECTED;
                r.sel_index = bst_pos;
                r.sel_id = bst_id;
            end else if (seen_scored) r.status = ST_LOWCOV;
            else r.status = ST_NONE;
            clear_best();
        end
        return r;
    endfunction

    // Check each response against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, o_data);
                fail_count++;
            end else begin
                t_out e;
                e = expected_results.pop_front();
                if (o_data !== e) begin
                    $display("%0t: mismatch expected %p actual %p", $time, e, o_data);
                    fail_count++;
                end
            end
        end
    end

    // Drive receiver ready: random stalls or a long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else if (hold_off) i_ready <= 1'b0;
        else i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on accepted traffic
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_MODE:   sh_mode = val[2:0];
            REG_MINCOV: sh_min_cov = val;
            default:    sh_family = val[0];
        endcase
        @(posedge i_clk);
    endtask

    // Drain all expectations, then let the block settle before a write
    task automatic drain();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    // Send one request, with a random gap, and queue its expectation
    task automatic send_request(input t_in c);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= c;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_results.insert(expected_results.size(), select_step(c));
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(15);
            3: return $urandom_range(1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in rand_candidate(input bit well_formed);
        t_in c;
        c.item_present = well_formed ? 1'($urandom_range(15) != 0) : 1'($urandom_range(1));
        c.last_item = $urandom_range(5) == 0;
        c.cand_id = $urandom_range(3) == 0 ? $urandom_range(7) : $urandom;
        c.allowed = well_formed ? 1'($urandom_range(7) != 0) : 1'($urandom_range(1));
        c.score_valid = well_formed ? 1'($urandom_range(7) != 0) : 1'($urandom_range(1));
        c.segment_valid = well_formed ? 1'($urandom_range(7) != 0) : 1'($urandom_range(1));
        // Small cost pool forces ties down the chain
        c.total_cost = $urandom_range(1) ? $urandom_range(3) : rand_word();
        c.duration = $urandom_range(1) ? $urandom_range(3) : rand_word();
        c.distance = $urandom_range(1) ? $urandom_range(3) : rand_word();
        c.analyzed_distance = rand_word();
        c.unknown_distance = $urandom_range(1) ? c.analyzed_distance >> $urandom_range(8)
                                               : rand_word();
        c.share_distance = $urandom_range(1) ? c.analyzed_distance >> $urandom_range(6)
                                             : rand_word();
        return c;
    endfunction

    t_in stim_table[20];
    t_out stim_expect[20];
    bit stim_typed[20];

    initial begin
        t_in c;
        c = '0;
        fail_count = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        sh_mode = MODE_FIRST;
        sh_min_cov = '0;
        sh_family = 1'b1;
        clear_best();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: typed rows first, predictor for the rest
        foreach (stim_table[k]) begin
            stim_table[k] = '0;
            stim_expect[k] = '0;
            stim_typed[k] = 1'b0;
        end
        // empty list closes with no candidates
        stim_table[0].last_item = 1'b1;
        stim_typed[0] = 1'b1;
        stim_expect[0].decision_valid = 1'b1;
        stim_expect[0].status = ST_EMPTY;
        // present but not allowed: none allowed
        stim_table[1] = '{item_present: 1, last_item: 1, cand_id: 32'hFFFF_FFFF,
            score_valid: 1, total_cost: 32'hFFFF_FFFF, default: '0};
        stim_typed[1] = 1'b1;
        stim_expect[1].evidence_route_id = 32'hFFFF_FFFF;
        stim_expect[1].decision_valid = 1'b1;
        stim_expect[1].status = ST_NONE;
        // mode first, single candidate selected
        stim_table[2] = '{item_present: 1, last_item: 1, cand_id: 32'd7, allowed: 1,
            score_valid: 1, default: '0};
        stim_typed[2] = 1'b1;
        stim_expect[2] = '{evidence_route_id: 32'd7, eligible: 1, cov_q16: Q16_ONE,
            decision_valid: 1, status: ST_SELECTED, sel_id: 32'd7,
            default: '0};
        // first-wins list: later candidates never replace
        for (int k = 3; k < 7; k++) begin
            stim_table[k] = '{item_present: 1, allowed: 1, score_valid: 1,
                cand_id: 32'(10 - k), default: '0};
        end
        stim_table[6].last_item = 1'b1;
        foreach (stim_table[k]) begin
            send_request(stim_table[k]);
            if (k < 7 && stim_typed[k] && expected_results[$] !== stim_expect[k]) begin
                $display("%0t: table row %0d expected %p actual %p", $time, k,
                         stim_expect[k], expected_results[$]);
                fail_count++;
            end
            if (k == 6) break;
        end
        drain();

        // Cost mode: ties down the chain
        write_reg(REG_MODE, 17'(MODE_COST));
        for (int k = 0; k < 6; k++) begin
            c = '{item_present: 1, allowed: 1, score_valid: 1, total_cost: 32'd5,
                duration: 32'(k < 2 ? 9 : 3), distance: 32'(k < 4 ? 8 : 2),
                cand_id: 32'(100 - k), last_item: (k == 5), default: '0};
            send_request(c);
        end
        drain();

        // Major: zero analyzed, all unknown, full share, coverage floor; mode 7
        write_reg(REG_MODE, 17'(MODE_MAJOR));
        write_reg(REG_MINCOV, 17'h10000);
        c = '{item_present: 1, allowed: 1, score_valid: 1, segment_valid: 1,
            cand_id: 32'd1, default: '0};
        send_request(c);
        c.analyzed_distance = 32'hFFFF_FFFF;
        c.unknown_distance = 32'hFFFF_FFFF;
        send_request(c);
        c.unknown_distance = 32'd0;
        c.share_distance = 32'hFFFF_FFFF;
        send_request(c);
        c.segment_valid = 1'b0;
        c.last_item = 1'b1;
        send_request(c);
        drain();
        write_reg(REG_MODE, 17'd7);
        write_reg(REG_MINCOV, 17'd0);
        c = '{item_present: 1, allowed: 1, score_valid: 1, segment_valid: 1,
            analyzed_distance: 32'd100, last_item: 1, default: '0};
        send_request(c);
        drain();
        write_reg(REG_FAMILY, 17'd0);
        send_request(c);
        drain();
        write_reg(REG_FAMILY, 17'd1);

        // Random phases over settings and idling patterns
        for (int ph = 0; ph < 14; ph++) begin
            int n;
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 87; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 87; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            write_reg(REG_MODE, 17'(ph % 7 == 6 ? $urandom_range(7) : ph % 6));
            case ($urandom_range(3))
                0: write_reg(REG_MINCOV, 17'd0);
                1: write_reg(REG_MINCOV, 17'h10000);
                default: write_reg(REG_MINCOV, 17'($urandom_range(65536)));
            endcase
            write_reg(REG_FAMILY, 17'($urandom_range(9) != 0));
            if (ph == 5) begin
                // Long receiver hold-off while requests keep coming
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (600) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            n = 75;
            for (int k = 0; k < n; k++) begin
                send_request(rand_candidate($urandom_range(9) != 0));
                if (k == n / 2 && ph == 3) drain();
            end
            // close any open list before touching configuration
            c = rand_candidate(1'b1);
            c.last_item = 1'b1;
            send_request(c);
            drain();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
